>>> design/file_retention_table_assert.svh
// Assertion macros for the file retention table.
// Used by file_retention_table.sv; expects clk and rst_n in scope.
`ifndef FILE_RETENTION_TABLE_ASSERT_SVH
`define FILE_RETENTION_TABLE_ASSERT_SVH

// Same-cycle implication.
`define FRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("file_retention_table assertion failed");

// Next-cycle implication.
`define FRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("file_retention_table assertion failed");

`endif

>>> design/frt_pkg.sv
// Shared types and constants of the file retention table.
// Used by frt_scan.sv and file_retention_table.sv.
`default_nettype none

package frt_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int NUM_CAND = 7;

    localparam logic [1:0] TIER_RAW = 2'd0;
    localparam logic [1:0] TIER_SNAPSHOT = 2'd1;
    localparam logic [1:0] TIER_BOOKEND = 2'd2;

    localparam logic [2:0] ACT_FEED = 3'd0;
    localparam logic [2:0] ACT_UPDATE = 3'd1;
    localparam logic [2:0] ACT_DROP = 3'd2;
    localparam logic [2:0] ACT_PICK = 3'd3;
    localparam logic [2:0] ACT_PICK_RAW = 3'd4;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_MERGED = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_FOUND = 3'd4;
    localparam logic [2:0] ST_NO_VICTIM = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    // Candidate classes tracked during a scan.
    localparam int C_ACKED = 0;
    localparam int C_TIER0 = 1;
    localparam int C_TIER1 = 2;
    localparam int C_TIER2 = 3;
    localparam int C_RAW_ACKED = 4;
    localparam int C_RAW_UNACKED = 5;
    localparam int C_INACTIVE = 6;

    typedef struct packed {
        logic [19:0] file_index;
        logic [1:0]  tier;
        logic        closed;
        logic        active;
        logic        known;
        logic [31:0] bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                              found;
        logic [SLOT_W-1:0]                 found_slot;
        logic                              free_ok;
        logic [SLOT_W-1:0]                 free_slot;
        logic [NUM_CAND-1:0]               cand_ok;
        logic [NUM_CAND-1:0][SLOT_W-1:0]   cand_slot;
        logic [19:0]                       inactive_idx;
    } scan_res_t;

endpackage

`default_nettype wire

>>> design/frt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module frt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 58
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/frt_scan.sv
// Scan unit: takes one entry per cycle while en is high and tracks matches and oldest candidates.
// Depends on frt_pkg.
`default_nettype none

module frt_scan (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      en,
    input  wire logic [frt_pkg::SLOT_W-1:0] slot,
    input  wire frt_pkg::entry_t           ent,
    input  wire logic                      ent_valid,
    input  wire logic [19:0]               key,
    input  wire logic signed [20:0]        acked,
    output frt_pkg::scan_res_t             res
);

    logic                                         found_reg;
    logic [frt_pkg::SLOT_W-1:0]                   found_slot_reg;
    logic                                         free_ok_reg;
    logic [frt_pkg::SLOT_W-1:0]                   free_slot_reg;
    logic [frt_pkg::NUM_CAND-1:0]                 ok_reg;
    logic [frt_pkg::NUM_CAND-1:0][frt_pkg::SLOT_W-1:0] slot_reg;
    logic [frt_pkg::NUM_CAND-1:0][19:0]           idx_reg;
    logic [frt_pkg::NUM_CAND-1:0]                 cond;
    logic                                         live;
    logic                                         is_acked;
    logic                                         is_raw;

    always_comb
    begin
        live = ent_valid && !ent.active;
        is_acked = $signed({1'b0, ent.file_index}) <= acked;
        is_raw = ent.tier == frt_pkg::TIER_RAW;
        cond[frt_pkg::C_ACKED] = live && is_acked;
        cond[frt_pkg::C_TIER0] = live && is_raw;
        cond[frt_pkg::C_TIER1] = live && (ent.tier == frt_pkg::TIER_SNAPSHOT);
        cond[frt_pkg::C_TIER2] = live && (ent.tier == frt_pkg::TIER_BOOKEND);
        cond[frt_pkg::C_RAW_ACKED] = live && is_raw && is_acked;
        cond[frt_pkg::C_RAW_UNACKED] = live && is_raw && !is_acked;
        cond[frt_pkg::C_INACTIVE] = live;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            ok_reg <= '0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            ok_reg <= '0;
        end
        else if (en)
        begin
            if (!found_reg && ent_valid && ent.file_index == key)
            begin
                found_reg <= 1'b1;
                found_slot_reg <= slot;
            end
            if (!free_ok_reg && !ent_valid)
            begin
                free_ok_reg <= 1'b1;
                free_slot_reg <= slot;
            end
            for (int k = 0; k < frt_pkg::NUM_CAND; k++)
            begin
                if (cond[k] && (!ok_reg[k] || ent.file_index < idx_reg[k]))
                begin
                    ok_reg[k] <= 1'b1;
                    slot_reg[k] <= slot;
                    idx_reg[k] <= ent.file_index;
                end
            end
        end
    end

    assign res.found = found_reg;
    assign res.found_slot = found_slot_reg;
    assign res.free_ok = free_ok_reg;
    assign res.free_slot = free_slot_reg;
    assign res.cand_ok = ok_reg;
    assign res.cand_slot = slot_reg;
    assign res.inactive_idx = idx_reg[frt_pkg::C_INACTIVE];

endmodule

`default_nettype wire

>>> design/file_retention_table.sv
// Top level of the file retention table: control sequencer, valid bits and totals.
// Depends on frt_pkg, frt_ram, frt_scan and file_retention_table_assert.svh.
`default_nettype none

// Each transaction is a full scan of the entry memory, which has a single read
// port: all CAPACITY entries are read one per cycle, then the chosen entry is
// read once more and, where the operation changes it, written back. The states
// run scan, drain, decide, fetch, apply and result, and the next input can be
// accepted in the cycle after the result is taken. One transaction is handled
// at a time. The raw-tier byte sum is kept as a running total. No clearing pass
// is needed after reset; entry validity is held in flip-flops.
module file_retention_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action, file_index, tier, is_log, byte_count, is_active, acked_through
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status, victim_valid, victim_index, victim_tier, victim_closed,
    // victim_acked, raw_tier_bytes, entry_count, zero fill
    output logic [71:0]      m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_FETCH, S_APPLY, S_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_ADD, OP_MERGE, OP_EVICT, OP_REJECT, OP_UPDATE, OP_DROP,
        OP_VICTIM, OP_NO_VICTIM, OP_NOT_FOUND, OP_DONE
    } op_t;

    localparam logic [frt_pkg::SLOT_W-1:0] LAST_SLOT = frt_pkg::SLOT_W'(frt_pkg::CAPACITY - 1);

    state_t                        state_reg;
    op_t                           op_reg, op_next;
    logic [frt_pkg::SLOT_W-1:0]    target_reg, target_next;
    logic [frt_pkg::SLOT_W-1:0]    scan_cnt_reg;
    logic                          pend_reg;
    logic [frt_pkg::SLOT_W-1:0]    pend_slot_reg;
    logic [frt_pkg::CAPACITY-1:0]  valid_reg;
    logic [frt_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [31:0]                   sum_reg, sum_next;
    logic [71:0]                   out_reg, out_next;

    logic [2:0]                    in_action_reg;
    logic [19:0]                   in_index_reg;
    logic [1:0]                    in_tier_reg;
    logic                          in_log_reg;
    logic [31:0]                   in_bytes_reg;
    logic                          in_active_reg;
    logic signed [20:0]            in_acked_reg;

    logic                          ram_we;
    logic [frt_pkg::SLOT_W-1:0]    ram_raddr;
    frt_pkg::entry_t               ram_wdata;
    frt_pkg::entry_t               ram_rdata;
    logic [frt_pkg::ENTRY_W-1:0]   ram_rdata_bits;
    frt_pkg::scan_res_t            scan_res;
    frt_pkg::entry_t               inc;
    logic [31:0]                   old_contrib;
    logic                          set_valid, clr_valid;
    logic [2:0]                    status;
    logic                          vic_valid;
    frt_pkg::entry_t               vic;
    logic                          accept_in;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = state_reg == S_RESULT;
    assign m_axis_tdata = out_reg;
    assign ram_raddr = (state_reg == S_SCAN) ? scan_cnt_reg : target_reg;
    assign ram_rdata = frt_pkg::entry_t'(ram_rdata_bits);

    frt_ram #(
        .DEPTH(frt_pkg::CAPACITY),
        .WIDTH(frt_pkg::ENTRY_W)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(target_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_bits)
    );

    frt_scan u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .start(accept_in),
        .en(pend_reg),
        .slot(pend_slot_reg),
        .ent(ram_rdata),
        .ent_valid(valid_reg[pend_slot_reg]),
        .key(in_index_reg),
        .acked(in_acked_reg),
        .res(scan_res)
    );

    always_comb
    begin
        op_next = OP_DONE;
        target_next = target_reg;
        unique case (in_action_reg)
            frt_pkg::ACT_FEED:
            begin
                if (scan_res.found)
                begin
                    op_next = OP_MERGE;
                    target_next = scan_res.found_slot;
                end
                else if (scan_res.free_ok)
                begin
                    op_next = OP_ADD;
                    target_next = scan_res.free_slot;
                end
                else if (!scan_res.cand_ok[frt_pkg::C_INACTIVE]
                         || in_index_reg < scan_res.inactive_idx)
                begin
                    op_next = OP_REJECT;
                end
                else
                begin
                    op_next = OP_EVICT;
                    target_next = scan_res.cand_slot[frt_pkg::C_INACTIVE];
                end
            end
            frt_pkg::ACT_UPDATE, frt_pkg::ACT_DROP:
            begin
                target_next = scan_res.found_slot;
                if (!scan_res.found)
                begin
                    op_next = OP_NOT_FOUND;
                end
                else if (in_action_reg == frt_pkg::ACT_UPDATE)
                begin
                    op_next = OP_UPDATE;
                end
                else
                begin
                    op_next = OP_DROP;
                end
            end
            frt_pkg::ACT_PICK:
            begin
                op_next = OP_VICTIM;
                priority if (scan_res.cand_ok[frt_pkg::C_ACKED])
                    target_next = scan_res.cand_slot[frt_pkg::C_ACKED];
                else if (scan_res.cand_ok[frt_pkg::C_TIER0])
                    target_next = scan_res.cand_slot[frt_pkg::C_TIER0];
                else if (scan_res.cand_ok[frt_pkg::C_TIER1])
                    target_next = scan_res.cand_slot[frt_pkg::C_TIER1];
                else if (scan_res.cand_ok[frt_pkg::C_TIER2])
                    target_next = scan_res.cand_slot[frt_pkg::C_TIER2];
                else
                    op_next = OP_NO_VICTIM;
            end
            frt_pkg::ACT_PICK_RAW:
            begin
                op_next = OP_VICTIM;
                priority if (scan_res.cand_ok[frt_pkg::C_RAW_ACKED])
                    target_next = scan_res.cand_slot[frt_pkg::C_RAW_ACKED];
                else if (scan_res.cand_ok[frt_pkg::C_RAW_UNACKED])
                    target_next = scan_res.cand_slot[frt_pkg::C_RAW_UNACKED];
                else
                    op_next = OP_NO_VICTIM;
            end
            default:
            begin
                op_next = OP_DONE;
            end
        endcase
    end

    always_comb
    begin
        inc.file_index = in_index_reg;
        inc.tier = in_tier_reg;
        inc.closed = in_log_reg;
        inc.active = 1'b0;
        inc.known = 1'b0;
        inc.bytes = '0;
        old_contrib = (ram_rdata.tier == frt_pkg::TIER_RAW && ram_rdata.known)
                      ? ram_rdata.bytes : 32'd0;
        ram_we = 1'b0;
        ram_wdata = ram_rdata;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        count_next = count_reg;
        sum_next = sum_reg;
        status = frt_pkg::ST_DONE;
        vic_valid = 1'b0;
        vic = ram_rdata;
        unique case (op_reg)
            OP_ADD:
            begin
                ram_we = 1'b1;
                ram_wdata = inc;
                set_valid = 1'b1;
                count_next = count_reg + 1'b1;
                status = frt_pkg::ST_ADDED;
            end
            OP_MERGE:
            begin
                if (!ram_rdata.closed && in_log_reg)
                begin
                    ram_we = 1'b1;
                    ram_wdata.closed = 1'b1;
                    ram_wdata.known = 1'b0;
                    sum_next = sum_reg - old_contrib;
                end
                status = frt_pkg::ST_MERGED;
            end
            OP_EVICT:
            begin
                ram_we = 1'b1;
                ram_wdata = inc;
                sum_next = sum_reg - old_contrib;
                vic_valid = 1'b1;
                status = frt_pkg::ST_EVICTED;
            end
            OP_REJECT:
            begin
                vic = inc;
                vic_valid = 1'b1;
                status = frt_pkg::ST_REJECTED;
            end
            OP_UPDATE:
            begin
                ram_we = 1'b1;
                ram_wdata.bytes = in_bytes_reg;
                ram_wdata.known = 1'b1;
                ram_wdata.active = in_active_reg;
                sum_next = sum_reg - old_contrib
                           + ((ram_rdata.tier == frt_pkg::TIER_RAW) ? in_bytes_reg : 32'd0);
            end
            OP_DROP:
            begin
                clr_valid = 1'b1;
                count_next = count_reg - 1'b1;
                sum_next = sum_reg - old_contrib;
            end
            OP_VICTIM:
            begin
                vic_valid = 1'b1;
                status = frt_pkg::ST_FOUND;
            end
            OP_NO_VICTIM:
            begin
                status = frt_pkg::ST_NO_VICTIM;
            end
            OP_NOT_FOUND:
            begin
                status = frt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                status = frt_pkg::ST_DONE;
            end
        endcase
        if (state_reg != S_APPLY)
        begin
            ram_we = 1'b0;
            set_valid = 1'b0;
            clr_valid = 1'b0;
        end
        out_next = '0;
        out_next[2:0] = status;
        if (vic_valid)
        begin
            out_next[3] = 1'b1;
            out_next[23:4] = vic.file_index;
            out_next[25:24] = vic.tier;
            out_next[26] = vic.closed;
            out_next[27] = $signed({1'b0, vic.file_index}) <= in_acked_reg;
        end
        out_next[59:28] = sum_next;
        out_next[68:60] = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_DONE;
            target_reg <= '0;
            scan_cnt_reg <= '0;
            pend_reg <= 1'b0;
            pend_slot_reg <= '0;
            valid_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            pend_reg <= state_reg == S_SCAN;
            pend_slot_reg <= scan_cnt_reg;
            if (set_valid)
            begin
                valid_reg[target_reg] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[target_reg] <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        in_action_reg <= s_axis_tdata[2:0];
                        in_index_reg <= s_axis_tdata[22:3];
                        in_tier_reg <= s_axis_tdata[24:23];
                        in_log_reg <= s_axis_tdata[25];
                        in_bytes_reg <= s_axis_tdata[57:26];
                        in_active_reg <= s_axis_tdata[58];
                        in_acked_reg <= s_axis_tdata[79:59];
                        scan_cnt_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == LAST_SLOT)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    op_reg <= op_next;
                    target_reg <= target_next;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    count_reg <= count_next;
                    sum_reg <= sum_next;
                    out_reg <= out_next;
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Assertions.
`include "file_retention_table_assert.svh"

    `FRT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= frt_pkg::COUNT_W'(frt_pkg::CAPACITY))
    `FRT_ASSERT_NOW(a_one_at_a_time, m_axis_tvalid, !s_axis_tready)
    `FRT_ASSERT_NEXT(a_accept_scans, accept_in, state_reg == S_SCAN && scan_cnt_reg == '0)
    `FRT_ASSERT_NOW(a_write_only_apply, ram_we, state_reg == S_APPLY)

endmodule

`default_nettype wire

>>> bench/file_retention_table_checker.sv
// Checker for the file retention table: watches both stream channels, predicts each result.
// Depends on frt_pkg for the capacity, tier, action and status codes.
`timescale 1ns / 1ps

module file_retention_table_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,
    output int               errors,
    output int               pending,
    output int               ops_seen,
    output int               full_feeds
);

    localparam int SEL_ACKED = 0;
    localparam int SEL_TIER = 1;
    localparam int SEL_RAW = 2;
    localparam int SEL_ANY = 3;

    typedef struct packed {
        logic signed [20:0] acked_through;
        logic               is_active;
        logic [31:0]        byte_count;
        logic               is_log;
        logic [1:0]         tier;
        logic [19:0]        file_index;
        logic [2:0]         action;
    } op_t;

    typedef struct packed {
        logic [2:0]  fill;
        logic [8:0]  entry_count;
        logic [31:0] raw_tier_bytes;
        logic        victim_acked;
        logic        victim_closed;
        logic [1:0]  victim_tier;
        logic [19:0] victim_index;
        logic        victim_valid;
        logic [2:0]  status;
    } outcome_t;

    typedef struct {
        bit        valid;
        bit [19:0] idx;
        bit [1:0]  tier;
        bit        closed;
        bit        active;
        bit        known;
        bit [31:0] bytes;
    } file_rec_t;

    file_rec_t files[frt_pkg::CAPACITY];
    int        file_count;
    outcome_t  expected_outcomes[$];

    function automatic bit acked_by(bit [19:0] idx, int acked);
        return int'(idx) <= acked;
    endfunction

    function automatic int lookup(bit [19:0] idx);
        for (int i = 0; i < frt_pkg::CAPACITY; i++)
            if (files[i].valid && files[i].idx == idx)
                return i;
        return -1;
    endfunction

    function automatic int oldest(int sel, bit [1:0] t, bit want, int acked);
        int best;
        best = -1;
        for (int i = 0; i < frt_pkg::CAPACITY; i++)
        begin
            if (!files[i].valid || files[i].active)
                continue;
            if (sel == SEL_ACKED && !acked_by(files[i].idx, acked))
                continue;
            if (sel == SEL_TIER && files[i].tier != t)
                continue;
            if (sel == SEL_RAW && (files[i].tier != frt_pkg::TIER_RAW ||
                                   acked_by(files[i].idx, acked) != want))
                continue;
            if (best < 0 || files[i].idx < files[best].idx)
                best = i;
        end
        return best;
    endfunction

    function automatic void describe(ref outcome_t r, input file_rec_t f, input int acked);
        r.victim_valid = 1'b1;
        r.victim_index = f.idx;
        r.victim_tier = f.tier;
        r.victim_closed = f.closed;
        r.victim_acked = acked_by(f.idx, acked);
    endfunction

    function automatic outcome_t apply_op(op_t op);
        outcome_t  r;
        file_rec_t inc;
        int        s;
        int        acked;
        bit [31:0] sum;
        r = '0;
        acked = op.acked_through;
        r.status = frt_pkg::ST_DONE;
        case (op.action)
            frt_pkg::ACT_FEED:
            begin
                s = lookup(op.file_index);
                if (s >= 0)
                begin
                    if (!files[s].closed && op.is_log)
                    begin
                        files[s].closed = 1'b1;
                        files[s].known = 1'b0;
                    end
                    r.status = frt_pkg::ST_MERGED;
                end
                else
                begin
                    inc = '{valid: 1'b1, idx: op.file_index, tier: op.tier,
                            closed: op.is_log, default: '0};
                    if (file_count < frt_pkg::CAPACITY)
                    begin
                        for (int i = 0; i < frt_pkg::CAPACITY; i++)
                            if (!files[i].valid)
                            begin
                                s = i;
                                break;
                            end
                        files[s] = inc;
                        file_count++;
                        r.status = frt_pkg::ST_ADDED;
                    end
                    else
                    begin
                        full_feeds++;
                        s = oldest(SEL_ANY, 2'd0, 1'b0, acked);
                        if (s < 0 || op.file_index < files[s].idx)
                        begin
                            describe(r, inc, acked);
                            r.status = frt_pkg::ST_REJECTED;
                        end
                        else
                        begin
                            describe(r, files[s], acked);
                            files[s] = inc;
                            r.status = frt_pkg::ST_EVICTED;
                        end
                    end
                end
            end
            frt_pkg::ACT_UPDATE, frt_pkg::ACT_DROP:
            begin
                s = lookup(op.file_index);
                if (s < 0)
                    r.status = frt_pkg::ST_NOT_FOUND;
                else if (op.action == frt_pkg::ACT_UPDATE)
                begin
                    files[s].bytes = op.byte_count;
                    files[s].known = 1'b1;
                    files[s].active = op.is_active;
                end
                else
                begin
                    files[s].valid = 1'b0;
                    file_count--;
                end
            end
            frt_pkg::ACT_PICK, frt_pkg::ACT_PICK_RAW:
            begin
                if (op.action == frt_pkg::ACT_PICK)
                begin
                    s = oldest(SEL_ACKED, 2'd0, 1'b1, acked);
                    if (s < 0) s = oldest(SEL_TIER, frt_pkg::TIER_RAW, 1'b0, acked);
                    if (s < 0) s = oldest(SEL_TIER, frt_pkg::TIER_SNAPSHOT, 1'b0, acked);
                    if (s < 0) s = oldest(SEL_TIER, frt_pkg::TIER_BOOKEND, 1'b0, acked);
                end
                else
                begin
                    s = oldest(SEL_RAW, 2'd0, 1'b1, acked);
                    if (s < 0) s = oldest(SEL_RAW, 2'd0, 1'b0, acked);
                end
                if (s < 0)
                    r.status = frt_pkg::ST_NO_VICTIM;
                else
                begin
                    describe(r, files[s], acked);
                    r.status = frt_pkg::ST_FOUND;
                end
            end
            default: r.status = frt_pkg::ST_DONE;
        endcase
        sum = '0;
        for (int i = 0; i < frt_pkg::CAPACITY; i++)
            if (files[i].valid && files[i].known && files[i].tier == frt_pkg::TIER_RAW)
                sum += files[i].bytes;
        r.raw_tier_bytes = sum;
        r.entry_count = file_count[8:0];
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            foreach (files[i]) files[i] = '{default: '0};
            file_count = 0;
            expected_outcomes.delete();
            errors = 0;
            pending = 0;
            ops_seen = 0;
            full_feeds = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_outcomes.push_back(apply_op(op_t'(s_axis_tdata)));
                ops_seen++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = outcome_t'(m_axis_tdata);
                if (expected_outcomes.size() == 0)
                begin
                    $error("Result transaction arrived with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("victim_valid", want.victim_valid, got.victim_valid);
                    check_field("victim_index", want.victim_index, got.victim_index);
                    check_field("victim_tier", want.victim_tier, got.victim_tier);
                    check_field("victim_closed", want.victim_closed, got.victim_closed);
                    check_field("victim_acked", want.victim_acked, got.victim_acked);
                    check_field("raw_tier_bytes", want.raw_tier_bytes, got.raw_tier_bytes);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("fill", 0, got.fill);
                end
            end
            pending = expected_outcomes.size();
        end
    end

endmodule

>>> bench/tb_file_retention_table.sv
// Testbench top for the file retention table: clock, reset, stimulus, stalls and verdict.
// Depends on file_retention_table, frt_pkg and file_retention_table_checker.
`timescale 1ns / 1ps

module tb_file_retention_table;

    localparam int IDLE_LIMIT = 5000;

    // Action codes with no defined meaning, and the tier value with no name.
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;
    localparam logic [1:0] TIER_NONE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          ops_seen;
    int          full_feeds;
    int          results_taken = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    always #1 clk = ~clk;

    file_retention_table u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    file_retention_table_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .errors(errors),
        .pending(pending),
        .ops_seen(ops_seen),
        .full_feeds(full_feeds)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic send_op(logic [2:0] action, logic [19:0] idx, logic [1:0] tier,
                           logic is_log, logic [31:0] bytes, logic is_active,
                           int acked);
        int gap;
        logic signed [20:0] acked_bits;
        acked_bits = 21'(acked);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {acked_bits, is_active, bytes, is_log, tier, idx, action};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int feed_pct);
        int roll;
        logic [2:0] action;
        logic [19:0] idx;
        logic [31:0] bytes;
        int acked;
        roll = $urandom_range(0, 99);
        if (roll < feed_pct) action = frt_pkg::ACT_FEED;
        else if (roll < feed_pct + 15) action = frt_pkg::ACT_UPDATE;
        else if (roll < feed_pct + 22) action = frt_pkg::ACT_DROP;
        else if (roll < feed_pct + 28) action = frt_pkg::ACT_PICK;
        else if (roll < feed_pct + 34) action = frt_pkg::ACT_PICK_RAW;
        else action = 3'(frt_pkg::ACT_PICK + $urandom_range(0, 4));
        roll = $urandom_range(0, 99);
        if (roll < 90) idx = 20'($urandom_range(0, 450));
        else if (roll < 95) idx = 20'($urandom_range(0, 999999));
        else idx = 20'(999999 - $urandom_range(0, 3));
        roll = $urandom_range(0, 9);
        bytes = roll < 2 ? 32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom();
        roll = $urandom_range(0, 9);
        if (roll == 0) acked = -1;
        else if (roll == 1) acked = 999999;
        else if (roll == 2) acked = int'($urandom_range(0, 999999));
        else acked = int'($urandom_range(0, 450));
        send_op(action, idx, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), bytes,
                $urandom_range(0, 3) == 0, acked);
    endtask

    always @(posedge clk)
    begin
        if (calm || stall_left == 0)
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 300))
                                                          : int'($urandom_range(1, 4));
        end
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            results_taken <= results_taken + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_file_retention_table NOT OK");
            $finish;
        end
    end

    initial
    begin
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(frt_pkg::ACT_FEED, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd999999, frt_pkg::TIER_BOOKEND, 1'b1, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd3, frt_pkg::TIER_RAW, 1'b1, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd7, TIER_NONE, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd12, frt_pkg::TIER_SNAPSHOT, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_UPDATE, 20'd0, frt_pkg::TIER_RAW, 1'b0, 32'hFFFF_FFFF, 1'b0, -1);
        send_op(frt_pkg::ACT_UPDATE, 20'd3, frt_pkg::TIER_RAW, 1'b0, 32'd2, 1'b1, -1);
        send_op(frt_pkg::ACT_UPDATE, 20'd5, frt_pkg::TIER_RAW, 1'b0, 32'd9, 1'b0, -1);
        send_op(frt_pkg::ACT_PICK, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_PICK_RAW, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_PICK, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, 999999);
        send_op(frt_pkg::ACT_PICK, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, 7);
        send_op(frt_pkg::ACT_FEED, 20'd0, frt_pkg::TIER_RAW, 1'b1, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd0, frt_pkg::TIER_RAW, 1'b1, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_FEED, 20'd12, frt_pkg::TIER_SNAPSHOT, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_PICK_RAW, 20'd0, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, 999999);
        send_op(frt_pkg::ACT_DROP, 20'd999999, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(frt_pkg::ACT_DROP, 20'd999999, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(ACT_SPARE_A, 20'd1, frt_pkg::TIER_RAW, 1'b1, 32'hFFFF_FFFF, 1'b1, 999999);
        send_op(ACT_SPARE_B, 20'd1, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);
        send_op(ACT_SPARE_C, 20'd1, frt_pkg::TIER_RAW, 1'b0, '0, 1'b0, -1);

        for (int i = 0; i < 520; i++)
        begin
            calm = (i >= 100 && i < 160);
            if (i == 250)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_random(i < 250 ? 78 : 50);
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);

        $display("Sent %0d operations, checked %0d results; %0d feeds hit a full table.",
                 ops_seen, results_taken, full_feeds);
        if (errors == 0 && pending == 0)
            $display("tb_file_retention_table OK");
        else
            $display("tb_file_retention_table NOT OK");
        $finish;
    end

endmodule
